### src/gcr_pkg.sv
package gcr_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_WIDE   = 2'd1;
  localparam logic [1:0] REQ_NARROW = 2'd2;

  localparam logic [1:0] CFG_WIDE_BASE   = 2'd0;
  localparam logic [1:0] CFG_NARROW_BASE = 2'd1;
  localparam logic [1:0] CFG_WIDE_ADV    = 2'd2;

  localparam logic [7:0] ADV_RESET = 8'd14;

  localparam logic [7:0]  LEAD_MIN   = 8'h81;
  localparam logic [7:0]  LEAD_MAX   = 8'hFE;
  localparam logic [7:0]  TRAIL_MIN  = 8'h40;
  localparam logic [7:0]  TRAIL_MAX  = 8'hFE;
  localparam logic [15:0] NARROW_MIN = 16'd33;
  localparam logic [15:0] NARROW_MAX = 16'd127;

  localparam logic [3:0] WIDE_LAST_WORD   = 4'd8;
  localparam logic [3:0] NARROW_LAST_WORD = 4'd15;
  localparam logic [3:0] WIDE_LAST_COL    = 4'd11;
  localparam logic [3:0] NARROW_KEEP_COL  = 4'd3;
  localparam logic [1:0] WIDE_PH_LAST     = 2'd2;

  localparam int BASE_W = 18;
  localparam int VAL_W  = 19;
  localparam int IDX_W  = 15;

  typedef struct packed {
    logic start;
    logic err;
    logic wide;
  } job_t;

  typedef struct packed {
    logic pend_free;
    logic stop;
  } ctl_t;

endpackage

### src/bitmap_glyph_column_renderer_top.sv
// Character generator over a synchronous glyph store of 16-bit words. A load
// word writes one store entry once its address has passed the wrap steps and
// the store state. A wide GBK draw folds the code into a glyph index, reads 9
// words and sends 12 columns; a narrow ASCII draw (33..127) reads up to 16
// words and sends one column per word, ending early at an all-zero column past
// column 3. Address setup passes the calc state and the wrap steps before the
// first store read, after which one column is formed per cycle while the
// output does not stall; the input stays closed until a glyph's last column
// has left the holding register. The wrap steps are R compare-subtract steps
// that wrap an address into the store depth: (20 - log2 depth) for depths up
// to 2^19 (2 at the default 262144), else 1. A bad code gives one registered
// error word; the next word can be taken once it leaves the holding register.
// Store entries read before being written return garbage.
module bitmap_glyph_column_renderer_top #(
  parameter int STORE_WORDS = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] char_code,
  input  logic [11:0] origin_x,
  input  logic [11:0] origin_y,
  input  logic [31:0] ink_color,
  input  logic [17:0] load_address,
  input  logic [15:0] load_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] column_x,
  output logic [11:0] top_y,
  output logic [15:0] column_bits,
  output logic [31:0] pixel_color,
  output logic [7:0]  advance,
  output logic        last_column,
  output logic        code_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import gcr_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic [17:0]   wide_base;
  logic [17:0]   narrow_base;
  logic [7:0]    wide_adv;
  logic          accept;
  logic          seq_busy;
  logic          unp_busy;
  job_t          job;
  ctl_t          ctl;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !seq_busy && !unp_busy;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_base   <= '0;
      narrow_base <= '0;
      wide_adv    <= ADV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDE_BASE:   wide_base   <= cfg_data;
        CFG_NARROW_BASE: narrow_base <= cfg_data;
        CFG_WIDE_ADV:    wide_adv    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  gcr_seq #(
    .STORE_WORDS (STORE_WORDS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .req_type     (req_type),
    .char_code    (char_code),
    .load_address (load_address),
    .load_word    (load_word),
    .wide_base    (wide_base),
    .narrow_base  (narrow_base),
    .ctl          (ctl),
    .job          (job),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .busy         (seq_busy)
  );

  gcr_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gcr_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .mem_re       (mem_re),
    .rdata        (mem_rdata),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .ink_color    (ink_color),
    .wide_advance (wide_adv),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .column_x     (column_x),
    .top_y        (top_y),
    .column_bits  (column_bits),
    .pixel_color  (pixel_color),
    .advance      (advance),
    .last_column  (last_column),
    .code_error   (code_error),
    .ctl          (ctl),
    .busy         (unp_busy)
  );

`ifndef SYNTHESIS
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && code_error) |-> (last_column && column_bits == 16'h0000))
    else $error("error word without last flag or with pixels");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store write and read in the same cycle");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> !in_ready)
    else $error("store read while input is open");
`endif

endmodule

### src/gcr_store.sv
module gcr_store #(
  parameter int STORE_WORDS = 262144,
  localparam int AW = $clog2(STORE_WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/gcr_seq.sv
module gcr_seq #(
  parameter int STORE_WORDS = 262144,
  localparam int AW = $clog2(STORE_WORDS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  logic [15:0]         char_code,
  input  logic [17:0]         load_address,
  input  logic [15:0]         load_word,
  input  logic [17:0]         wide_base,
  input  logic [17:0]         narrow_base,
  input  gcr_pkg::ctl_t       ctl,
  output gcr_pkg::job_t       job,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [15:0]         mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  output logic                busy
);
  import gcr_pkg::*;

  localparam int RED_STEPS = (VAL_W > AW) ? VAL_W - AW + 1 : 1;
  localparam int RW = ((VAL_W > AW) ? VAL_W : AW) + 1;
  localparam int SW = $clog2(RED_STEPS + 1);
  localparam logic [RW-1:0] TERM0 = RW'(STORE_WORDS) << (RED_STEPS - 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(RED_STEPS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_WORDS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_RED   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;

  logic [2:0]       state;
  logic [1:0]       mode;
  logic [IDX_W-1:0] idx;
  logic [RW-1:0]    val;
  logic [RW-1:0]    term;
  logic [SW-1:0]    step;
  logic [AW-1:0]    addr;
  logic [3:0]       rd_cnt;
  logic [15:0]      wdata;

  logic [7:0]       lead;
  logic [7:0]       trail;
  logic [6:0]       lead_off;
  logic [7:0]       trail_off;
  logic [IDX_W-1:0] wide_idx;
  logic [IDX_W-1:0] narrow_idx;
  logic             wide_err;
  logic             narrow_err;
  logic [RW-1:0]    val_red;
  logic [AW-1:0]    addr_next;
  logic             mode_wide;

  always_comb begin
    lead       = char_code[15:8];
    trail      = char_code[7:0];
    lead_off   = 7'(lead - LEAD_MIN);
    trail_off  = trail - TRAIL_MIN;
    // idx = lead_off * 191 + trail_off
    wide_idx   = IDX_W'({lead_off, 8'h00}) - IDX_W'({lead_off, 6'h00}) - IDX_W'(lead_off)
               + IDX_W'(trail_off);
    narrow_idx = IDX_W'(char_code[7:0] - NARROW_MIN[7:0]);
    wide_err   = (lead < LEAD_MIN) || (lead > LEAD_MAX) ||
                 (trail < TRAIL_MIN) || (trail > TRAIL_MAX);
    narrow_err = (char_code < NARROW_MIN) || (char_code > NARROW_MAX);
    job.start  = start && ((req_type == REQ_WIDE) || (req_type == REQ_NARROW));
    job.wide   = req_type == REQ_WIDE;
    job.err    = (req_type == REQ_WIDE) ? wide_err : narrow_err;
    val_red    = (val >= term) ? val - term : val;
    addr_next  = (addr == ADDR_LAST) ? '0 : addr + AW'(1);
    mode_wide  = mode == REQ_WIDE;
  end

  assign mem_re    = (state == S_RUN) && ctl.pend_free && !ctl.stop;
  assign mem_raddr = addr;
  assign mem_we    = state == S_STORE;
  assign mem_waddr = addr;
  assign mem_wdata = wdata;
  assign busy      = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (req_type == REQ_LOAD) begin
              state <= S_RED;
            end else if (job.start && !job.err) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          state <= S_RED;
        end
        S_RED: begin
          if (step == STEP_LAST) begin
            state <= (mode == REQ_LOAD) ? S_STORE : S_RUN;
          end
        end
        S_STORE: begin
          state <= S_IDLE;
        end
        S_RUN: begin
          if (ctl.stop) begin
            state <= S_IDLE;
          end else if (mem_re &&
                       rd_cnt == (mode_wide ? WIDE_LAST_WORD : NARROW_LAST_WORD)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    case (state)
      S_IDLE: begin
        mode  <= req_type;
        idx   <= (req_type == REQ_WIDE) ? wide_idx : narrow_idx;
        val   <= RW'(load_address);
        wdata <= load_word;
        term  <= TERM0;
        step  <= '0;
      end
      S_CALC: begin
        if (mode_wide) begin
          val <= RW'(wide_base) + RW'({idx, 3'b000}) + RW'(idx);
        end else begin
          val <= RW'(narrow_base) + RW'({idx, 4'h0});
        end
      end
      S_RED: begin
        val  <= val_red;
        term <= term >> 1;
        step <= step + SW'(1);
        if (step == STEP_LAST) begin
          addr   <= val_red[AW-1:0];
          rd_cnt <= '0;
        end
      end
      S_RUN: begin
        if (mem_re) begin
          addr   <= addr_next;
          rd_cnt <= rd_cnt + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/gcr_unpack.sv
module gcr_unpack (
  input  logic            clk,
  input  logic            rst,
  input  gcr_pkg::job_t   job,
  input  logic            mem_re,
  input  logic [15:0]     rdata,
  input  logic [11:0]     origin_x,
  input  logic [11:0]     origin_y,
  input  logic [31:0]     ink_color,
  input  logic [7:0]      wide_advance,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [12:0]     column_x,
  output logic [11:0]     top_y,
  output logic [15:0]     column_bits,
  output logic [31:0]     pixel_color,
  output logic [7:0]      advance,
  output logic            last_column,
  output logic            code_error,
  output gcr_pkg::ctl_t   ctl,
  output logic            busy
);
  import gcr_pkg::*;

  logic        wide;
  logic        pend;
  logic        extra;
  logic [11:0] extra_bits;
  logic [15:0] prev;
  logic [1:0]  ph;
  logic [3:0]  col;
  logic        h_valid;
  logic        h_err;
  logic [3:0]  h_col;
  logic [15:0] h_bits;
  logic [11:0] ox;
  logic [11:0] oy;
  logic [31:0] color;

  logic        o_free;
  logic        rd_zero;
  logic        narrow_last;
  logic        h_known;
  logic        h_last;
  logic        h_move;
  logic        drop;
  logic        from_pend;
  logic        h_take;
  logic [15:0] pend_bits;

  always_comb begin
    o_free      = !out_valid || out_ready;
    rd_zero     = rdata == 16'h0000;
    // narrow column is final once the next word is seen (or it is column 15)
    narrow_last = (h_col == NARROW_LAST_WORD) ||
                  (pend && rd_zero && (h_col >= NARROW_KEEP_COL));
    h_known     = h_err || wide || pend || (h_col == NARROW_LAST_WORD);
    h_last      = h_err || (wide ? (h_col == WIDE_LAST_COL) : narrow_last);
    h_move      = h_valid && h_known && o_free;
    drop        = h_move && !h_err && !wide && pend && rd_zero &&
                  (h_col >= NARROW_KEEP_COL);
    from_pend   = !extra && pend && !drop;
    h_take      = (extra || from_pend) && (!h_valid || h_move);
    ctl.pend_free = !pend || drop || (h_take && !extra);
    ctl.stop      = drop;

    if (extra) begin
      pend_bits = {extra_bits, 4'h0};
    end else if (wide) begin
      case (ph)
        2'd0:    pend_bits = {rdata[15:4], 4'h0};
        2'd1:    pend_bits = {prev[3:0], rdata[15:8], 4'h0};
        2'd2:    pend_bits = {prev[7:0], rdata[15:12], 4'h0};
        default: pend_bits = 16'h0000;
      endcase
    end else begin
      pend_bits = rdata;
    end
  end

  assign busy = pend || extra || h_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      extra     <= 1'b0;
      h_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= mem_re || (pend && !ctl.pend_free);
      if (h_take && extra) begin
        extra <= 1'b0;
      end else if (h_take && wide && (ph == WIDE_PH_LAST)) begin
        extra <= 1'b1;
      end
      if (job.start && job.err) begin
        h_valid <= 1'b1;
      end else if (h_take) begin
        h_valid <= 1'b1;
      end else if (h_move) begin
        h_valid <= 1'b0;
      end
      if (h_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (job.start) begin
      wide  <= job.wide;
      col   <= '0;
      ph    <= '0;
      ox    <= origin_x;
      oy    <= origin_y;
      color <= ink_color;
      if (job.err) begin
        h_err  <= 1'b1;
        h_col  <= '0;
        h_bits <= '0;
      end
    end else if (h_take) begin
      h_err  <= 1'b0;
      h_col  <= col;
      h_bits <= pend_bits;
      col    <= col + 4'd1;
      if (!extra) begin
        prev <= rdata;
        if (wide) begin
          ph <= (ph == WIDE_PH_LAST) ? 2'd0 : ph + 2'd1;
          if (ph == WIDE_PH_LAST) begin
            extra_bits <= rdata[11:0];
          end
        end
      end
    end

    if (h_move) begin
      column_x    <= h_err ? 13'd0 : 13'(ox) + 13'(h_col);
      top_y       <= h_err ? 12'd0 : oy;
      column_bits <= h_bits;
      pixel_color <= h_err ? 32'd0 : color;
      advance     <= h_err ? 8'd0 : (wide ? wide_advance : {1'b0, wide_advance[7:1]});
      last_column <= h_last;
      code_error  <= h_err;
    end
  end

endmodule

### bench/glyph_column_checker.sv
`timescale 1ns / 100ps
module glyph_column_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] char_code,
  input  logic [11:0] origin_x,
  input  logic [11:0] origin_y,
  input  logic [31:0] ink_color,
  input  logic [17:0] load_address,
  input  logic [15:0] load_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [12:0] column_x,
  input  logic [11:0] top_y,
  input  logic [15:0] column_bits,
  input  logic [31:0] pixel_color,
  input  logic [7:0]  advance,
  input  logic        last_column,
  input  logic        code_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          columns_checked
);
  import gcr_pkg::*;

  localparam int MAX_SHOWN = 50;

  typedef struct packed {
    logic [12:0] x;
    logic [11:0] y;
    logic [15:0] bits;
    logic [31:0] color;
    logic [7:0]  adv;
    logic        last;
    logic        err;
  } column_t;

  column_t     expected_cols[$];
  logic [15:0] glyph_words [bit [17:0]];
  logic [17:0] wide_base;
  logic [17:0] narrow_base;
  logic [7:0]  wide_adv;
  int          fails = 0;
  int          seen = 0;
  int          shown = 0;

  function automatic logic [15:0] fetch(input logic [17:0] addr);
    if (glyph_words.exists(addr)) return glyph_words[addr];
    return 16'h0000;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      fails++;
      if (shown < MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      shown++;
    end
  endtask

  task automatic render_word(input logic [1:0] kind, input logic [15:0] code,
                             input logic [11:0] ox, oy, input logic [31:0] color,
                             input logic [17:0] la, input logic [15:0] lw);
    column_t     c;
    column_t     run [16];
    logic [17:0] addr;
    logic [15:0] w1, w2, w3;
    logic [15:0] cols [4];
    logic [7:0]  lead, trail;
    int          idx, n;
    bit          stop;
    lead  = code[15:8];
    trail = code[7:0];
    c = '0;
    n = 0;
    stop = 0;
    case (kind)
      REQ_LOAD: glyph_words[la] = lw;
      REQ_WIDE: begin
        if (lead < LEAD_MIN || lead > LEAD_MAX || trail < TRAIL_MIN || trail > TRAIL_MAX) begin
          c.last = 1'b1;
          c.err  = 1'b1;
          expected_cols.push_back(c);
        end else begin
          idx  = (lead - LEAD_MIN) * 191 + (trail - TRAIL_MIN);
          addr = wide_base + 18'(idx * 9);
          c.y = oy;
          c.color = color;
          c.adv = wide_adv;
          for (int g = 0; g < 3; g++) begin
            w1 = fetch(addr + 18'(3 * g));
            w2 = fetch(addr + 18'(3 * g + 1));
            w3 = fetch(addr + 18'(3 * g + 2));
            cols[0] = {w1[15:4], 4'h0};
            cols[1] = {w1[3:0], w2[15:8], 4'h0};
            cols[2] = {w2[7:0], w3[15:12], 4'h0};
            cols[3] = {w3[11:0], 4'h0};
            for (int k = 0; k < 4; k++) begin
              c.x = 13'(ox) + 13'(n);
              c.bits = cols[k];
              c.last = (n == WIDE_LAST_COL);
              expected_cols.push_back(c);
              n++;
            end
          end
        end
      end
      REQ_NARROW: begin
        if (code < NARROW_MIN || code > NARROW_MAX) begin
          c.last = 1'b1;
          c.err  = 1'b1;
          expected_cols.push_back(c);
        end else begin
          addr = narrow_base + 18'((code - NARROW_MIN) * 16);
          c.y = oy;
          c.color = color;
          c.adv = wide_adv >> 1;
          for (int k = 0; k <= NARROW_LAST_WORD; k++) begin
            if (!stop) begin
              w1 = fetch(addr + 18'(k));
              if (w1 == 16'h0000 && k > NARROW_KEEP_COL) begin
                stop = 1;
              end else begin
                c.x = 13'(ox) + 13'(k);
                c.bits = w1;
                run[n] = c;
                n++;
              end
            end
          end
          run[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) expected_cols.push_back(run[k]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    column_t got, want;
    if (rst) begin
      wide_base = '0;
      narrow_base = '0;
      wide_adv = ADV_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDE_BASE:   wide_base = cfg_data;
          CFG_NARROW_BASE: narrow_base = cfg_data;
          CFG_WIDE_ADV:    wide_adv = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {column_x, top_y, column_bits, pixel_color, advance, last_column, code_error};
        seen++;
        if (expected_cols.size() == 0) begin
          fails++;
          if (shown < MAX_SHOWN)
            $display("%0t: column word, expected none, got x=%0d y=%0d bits=%h err=%b",
                     $time, got.x, got.y, got.bits, got.err);
          shown++;
        end else begin
          want = expected_cols.pop_front();
          flag_field("column_x", 32'(want.x), 32'(got.x));
          flag_field("top_y", 32'(want.y), 32'(got.y));
          flag_field("column_bits", 32'(want.bits), 32'(got.bits));
          flag_field("pixel_color", want.color, got.color);
          flag_field("advance", 32'(want.adv), 32'(got.adv));
          flag_field("last_column", 32'(want.last), 32'(got.last));
          flag_field("code_error", 32'(want.err), 32'(got.err));
        end
      end
      if (in_valid && in_ready)
        render_word(req_type, char_code, origin_x, origin_y, ink_color, load_address,
                    load_word);
    end
    mismatches <= fails;
    pending <= expected_cols.size();
    columns_checked <= seen;
  end

endmodule

### bench/tb_bitmap_glyph_column_renderer_top.sv
`timescale 1ns / 100ps
module tb_bitmap_glyph_column_renderer_top;
  import gcr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 100;
  localparam int PHASE_WORDS = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [15:0] char_code = '0;
  logic [11:0] origin_x = '0;
  logic [11:0] origin_y = '0;
  logic [31:0] ink_color = '0;
  logic [17:0] load_address = '0;
  logic [15:0] load_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] column_x;
  logic [11:0] top_y;
  logic [15:0] column_bits;
  logic [31:0] pixel_color;
  logic [7:0]  advance;
  logic        last_column;
  logic        code_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;
  int          mismatches;
  int          pending;
  int          columns_checked;

  logic [17:0] cur_wide_base;
  logic [17:0] cur_narrow_base;
  logic [15:0] shadow [bit [17:0]];
  logic [15:0] wide_codes[$];
  logic [15:0] narrow_codes[$];
  int          n_items = 0;
  int          n_loads = 0;
  int          n_wide = 0;
  int          n_narrow = 0;
  int          n_bad = 0;
  int          n_settings = 0;
  int          idle_cycles = 0;
  bit          burst = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bitmap_glyph_column_renderer_top dut (.*);

  glyph_column_checker column_check (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] rnd12();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] rnd16();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rnd32();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [17:0] wide_slot(input logic [15:0] code);
    int idx;
    idx = (code[15:8] - LEAD_MIN) * 191 + (code[7:0] - TRAIL_MIN);
    return cur_wide_base + 18'(idx * 9);
  endfunction

  function automatic logic [17:0] narrow_slot(input logic [15:0] code);
    return cur_narrow_base + 18'((code - NARROW_MIN) * 16);
  endfunction

  // every word the draw will read must already be in the store
  function automatic bit draw_ok(input logic [1:0] kind, input logic [15:0] code);
    logic [17:0] a;
    bit          ok, done;
    ok = 1;
    done = 0;
    if (kind == REQ_WIDE) begin
      a = wide_slot(code);
      for (int k = 0; k <= WIDE_LAST_WORD; k++)
        if (!shadow.exists(a + 18'(k))) ok = 0;
    end else begin
      a = narrow_slot(code);
      for (int k = 0; k <= NARROW_LAST_WORD; k++) begin
        if (!done) begin
          if (!shadow.exists(a + 18'(k))) begin
            ok = 0;
            done = 1;
          end else if (shadow[a + 18'(k)] == 16'h0000 && k > NARROW_KEEP_COL) begin
            done = 1;
          end
        end
      end
    end
    return ok;
  endfunction

  function automatic logic [15:0] pick_bad(input logic [1:0] kind);
    logic [15:0] c;
    int          r;
    r = $urandom_range(0, 5);
    if (kind == REQ_WIDE) begin
      case (r)
        0: c = {LEAD_MIN - 8'd1, 8'($urandom)};
        1: c = {LEAD_MAX + 8'd1, 8'($urandom)};
        2: c = {8'($urandom_range(LEAD_MIN, LEAD_MAX)), TRAIL_MIN - 8'd1};
        3: c = {8'($urandom_range(LEAD_MIN, LEAD_MAX)), TRAIL_MAX + 8'd1};
        default: begin
          c = 16'($urandom);
          while (c[15:8] >= LEAD_MIN && c[15:8] <= LEAD_MAX &&
                 c[7:0] >= TRAIL_MIN && c[7:0] <= TRAIL_MAX)
            c = 16'($urandom);
        end
      endcase
    end else begin
      case (r)
        0: c = NARROW_MIN - 16'd1;
        1: c = NARROW_MAX + 16'd1;
        2: c = 16'h0000;
        3: c = 16'hFFFF;
        default: begin
          c = 16'($urandom);
          while (c >= NARROW_MIN && c <= NARROW_MAX) c = 16'($urandom);
        end
      endcase
    end
    return c;
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [15:0] code,
                           input logic [11:0] ox, oy, input logic [31:0] color,
                           input logic [17:0] la, input logic [15:0] lw);
    int gap;
    in_valid <= 1'b1;
    req_type <= kind;
    char_code <= code;
    origin_x <= ox;
    origin_y <= oy;
    ink_color <= color;
    load_address <= la;
    load_word <= lw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind != REQ_UNUSED) n_items++;
    case (kind)
      REQ_LOAD: begin
        shadow[la] = lw;
        n_loads++;
      end
      REQ_WIDE:   n_wide++;
      REQ_NARROW: n_narrow++;
      default: ;
    endcase
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_word_at(input logic [17:0] la, input logic [15:0] lw);
    send_word(REQ_LOAD, 16'($urandom), rnd12(), rnd12(), rnd32(), la, lw);
  endtask

  task automatic draw(input logic [1:0] kind, input logic [15:0] code);
    send_word(kind, code, rnd12(), rnd12(), rnd32(), 18'($urandom), 16'($urandom));
  endtask

  task automatic load_wide_glyph(input logic [15:0] code);
    logic [17:0] a;
    a = wide_slot(code);
    for (int k = 0; k <= WIDE_LAST_WORD; k++) load_word_at(a + 18'(k), rnd16());
    wide_codes.push_back(code);
  endtask

  // columns past the fourth are nonzero up to the stop column, which holds zero
  task automatic load_narrow_glyph(input logic [15:0] code, input int stop_col);
    logic [17:0] a;
    logic [15:0] w;
    a = narrow_slot(code);
    for (int k = 0; k < stop_col; k++) begin
      w = rnd16();
      if (k > NARROW_KEEP_COL && w == 16'h0000) w = 16'($urandom_range(1, 65535));
      load_word_at(a + 18'(k), w);
    end
    if (stop_col <= NARROW_LAST_WORD) load_word_at(a + 18'(stop_col), 16'h0000);
    narrow_codes.push_back(code);
  endtask

  task automatic set_registers(input logic [17:0] wb, nb, input logic [7:0] adv);
    logic [1:0]  regs [3];
    logic [17:0] vals [3];
    regs = '{CFG_WIDE_BASE, CFG_NARROW_BASE, CFG_WIDE_ADV};
    vals = '{wb, nb, {10'($urandom), adv}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_wide_base = wb;
    cur_narrow_base = nb;
    n_settings++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic random_phase(input int words);
    int          start, r;
    logic [1:0]  kind;
    logic [15:0] code;
    wide_codes.delete();
    narrow_codes.delete();
    start = n_items;
    while (n_items - start < words) begin
      r = $urandom_range(0, 99);
      if (r < 7 || wide_codes.size() == 0) begin
        case ($urandom_range(0, 5))
          0: code = {LEAD_MIN, TRAIL_MIN};
          1: code = {LEAD_MAX, TRAIL_MAX};
          default: code = {8'($urandom_range(LEAD_MIN, LEAD_MAX)),
                           8'($urandom_range(TRAIL_MIN, TRAIL_MAX))};
        endcase
        load_wide_glyph(code);
      end else if (r < 14 || narrow_codes.size() == 0) begin
        case ($urandom_range(0, 5))
          0: code = NARROW_MIN;
          1: code = NARROW_MAX;
          default: code = 16'($urandom_range(NARROW_MIN, NARROW_MAX));
        endcase
        load_narrow_glyph(code, ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(4, 15));
      end else if (r < 78) begin
        if (r < 46) begin
          kind = REQ_WIDE;
          code = wide_codes[$urandom_range(0, wide_codes.size() - 1)];
        end else begin
          kind = REQ_NARROW;
          code = narrow_codes[$urandom_range(0, narrow_codes.size() - 1)];
        end
        if (draw_ok(kind, code)) begin
          draw(kind, code);
        end else begin
          draw(kind, pick_bad(kind));
          n_bad++;
        end
      end else if (r < 88) begin
        kind = ($urandom_range(0, 1) == 0) ? REQ_WIDE : REQ_NARROW;
        draw(kind, pick_bad(kind));
        n_bad++;
      end else if (r < 94) begin
        load_word_at(18'($urandom), rnd16());
      end else begin
        draw(REQ_UNUSED, 16'($urandom));
      end
    end
  endtask

  // output side: random stalls plus one long hold-off to back the block up
  initial begin : sink
    int  gap;
    bit  held;
    held = 0;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!held && columns_checked >= HOLD_AFTER) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = gap_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[bitmap_glyph_column_renderer_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] bad_wide [5];
    logic [15:0] bad_narrow [4];
    bad_wide = '{16'h8040, 16'hFF40, 16'h813F, 16'h81FF, 16'h0000};
    bad_narrow = '{NARROW_MIN - 16'd1, NARROW_MAX + 16'd1, 16'h0000, 16'hFFFF};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // glyph words wrap past the top of the store at these bases
    set_registers(18'h3FFFF, 18'h3FFFF, 8'hFF);
    load_wide_glyph({LEAD_MAX, TRAIL_MAX});
    load_narrow_glyph(NARROW_MIN, 4);
    load_word_at(narrow_slot(NARROW_MIN), 16'h0000);
    send_word(REQ_WIDE, {LEAD_MAX, TRAIL_MAX}, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, '1, '1);
    send_word(REQ_NARROW, NARROW_MIN, 12'h000, 12'h000, 32'h0, '0, '0);
    foreach (bad_wide[i]) draw(REQ_WIDE, bad_wide[i]);
    foreach (bad_narrow[i]) draw(REQ_NARROW, bad_narrow[i]);
    n_bad += 9;
    draw(REQ_UNUSED, 16'hFFFF);

    for (int ph = 1; ph <= 4; ph++) begin
      drain();
      case (ph)
        1: set_registers(18'h0, 18'h0, 8'h00);
        2: set_registers(18'($urandom), 18'($urandom), 8'($urandom_range(1, 254)));
        3: set_registers(18'($urandom_range(200000, 262143)), 18'($urandom), 8'h01);
        default: set_registers(18'($urandom), 18'($urandom), ADV_RESET);
      endcase
      burst = (ph == 2);
      random_phase(PHASE_WORDS);
    end
    burst = 0;
    drain();

    $display("Sent %0d input words: %0d loads, %0d wide and %0d narrow draws, %0d bad codes",
             n_items, n_loads, n_wide, n_narrow, n_bad);
    $display("over %0d register settings; %0d columns checked, one %0d-cycle output hold",
             n_settings, columns_checked, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("[bitmap_glyph_column_renderer_top] OK");
    end else begin
      $display("[bitmap_glyph_column_renderer_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/gcr_pkg.sv
src/gcr_store.sv
src/gcr_seq.sv
src/gcr_unpack.sv
src/bitmap_glyph_column_renderer_top.sv
bench/glyph_column_checker.sv
bench/tb_bitmap_glyph_column_renderer_top.sv
